// ===== rtl/crf_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package crf_pkg;

    localparam int TIME_W    = 64;
    localparam int DEVICE_W  = 16;
    localparam int KIND_W    = 8;
    localparam int LENGTH_W  = 16;
    localparam int LIMIT_W   = 32;
    localparam int TOTAL_W   = 32;
    localparam int ENABLES_W = 6;

    localparam int COUNT_WIDTH_DEF  = 32;
    localparam int DEVICE_WIDTH_DEF = 16;
    localparam int LENGTH_WIDTH_DEF = 16;

    localparam int APB_ADDR_W = 6;
    localparam int APB_DATA_W = 64;
    localparam int REG_IDX_W  = 3;
    localparam int REG_LSB    = 3;

    // check enable bit positions
    localparam int EN_START  = 0;
    localparam int EN_END    = 1;
    localparam int EN_DEVICE = 2;
    localparam int EN_KIND   = 3;
    localparam int EN_MINLEN = 4;
    localparam int EN_MAXLEN = 5;

    // counter bank slots
    localparam int CNT_NUM     = 6;
    localparam int CNT_SCANNED = 0;
    localparam int CNT_MATCHED = 1;
    localparam int CNT_TIME    = 2;
    localparam int CNT_DEVICE  = 3;
    localparam int CNT_KIND    = 4;
    localparam int CNT_PAYLOAD = 5;

    typedef enum logic [2:0] {
        VERDICT_MATCH   = 3'd0,
        VERDICT_TIME    = 3'd1,
        VERDICT_DEVICE  = 3'd2,
        VERDICT_KIND    = 3'd3,
        VERDICT_PAYLOAD = 3'd4,
        VERDICT_IGNORED = 3'd5
    } verdict_t;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_CHECK_ENABLES = 3'd0,
        REG_WINDOW_START  = 3'd1,
        REG_WINDOW_END    = 3'd2,
        REG_WANTED_DEVICE = 3'd3,
        REG_WANTED_KIND   = 3'd4,
        REG_LEAST_PAYLOAD = 3'd5,
        REG_MOST_PAYLOAD  = 3'd6,
        REG_MATCH_LIMIT   = 3'd7
    } reg_idx_t;

    // first member in the highest bits, so capture_time lands at tdata[63:0]
    typedef struct packed {
        logic [LENGTH_W-1:0] payload_length;
        logic [KIND_W-1:0]   packet_kind;
        logic [DEVICE_W-1:0] device_id;
        logic [TIME_W-1:0]   capture_time;
    } record_t;

    typedef struct packed {
        logic [ENABLES_W-1:0] check_enables;
        logic [TIME_W-1:0]    window_start;
        logic [TIME_W-1:0]    window_end;
        logic [DEVICE_W-1:0]  wanted_device;
        logic [KIND_W-1:0]    wanted_kind;
        logic [LENGTH_W-1:0]  least_payload;
        logic [LENGTH_W-1:0]  most_payload;
        logic [LIMIT_W-1:0]   match_limit;
    } cfg_t;

    typedef struct packed {
        logic     advance;
        verdict_t verdict;
    } step_t;

    typedef struct packed {
        verdict_t verdict;
        logic     limit_reached;
    } outcome_t;

    localparam int S_TDATA_W = $bits(record_t);
    localparam int M_BODY_W  = 3 + 1 + CNT_NUM * TOTAL_W;
    localparam int M_TDATA_W = ((M_BODY_W + 7) / 8) * 8;
    localparam int M_PAD_W   = M_TDATA_W - M_BODY_W;

endpackage

`default_nettype wire

// ===== rtl/crf_checks.sv =====
`timescale 1ns / 1ps
`default_nettype none

module crf_checks
    import crf_pkg::*;
#(
    parameter int DEVICE_WIDTH = DEVICE_WIDTH_DEF,
    parameter int LENGTH_WIDTH = LENGTH_WIDTH_DEF
) (
    input  record_t  rec,
    input  cfg_t     cfg,
    output verdict_t verdict
);

    localparam int DevBits = (DEVICE_WIDTH < DEVICE_W) ? DEVICE_WIDTH : DEVICE_W;
    localparam int LenBits = (LENGTH_WIDTH < LENGTH_W) ? LENGTH_WIDTH : LENGTH_W;

    logic time_fail;
    logic device_fail;
    logic kind_fail;
    logic length_fail;

    assign time_fail =
        (cfg.check_enables[EN_START] && (rec.capture_time < cfg.window_start)) ||
        (cfg.check_enables[EN_END]   && (rec.capture_time > cfg.window_end));

    assign device_fail = cfg.check_enables[EN_DEVICE] &&
        (rec.device_id[DevBits-1:0] != cfg.wanted_device[DevBits-1:0]);

    assign kind_fail = cfg.check_enables[EN_KIND] &&
        (rec.packet_kind != cfg.wanted_kind);

    assign length_fail =
        (cfg.check_enables[EN_MINLEN] &&
            (rec.payload_length[LenBits-1:0] < cfg.least_payload[LenBits-1:0])) ||
        (cfg.check_enables[EN_MAXLEN] &&
            (rec.payload_length[LenBits-1:0] > cfg.most_payload[LenBits-1:0]));

    // first failing check wins
    always_comb begin
        if (time_fail) begin
            verdict = VERDICT_TIME;
        end else if (device_fail) begin
            verdict = VERDICT_DEVICE;
        end else if (kind_fail) begin
            verdict = VERDICT_KIND;
        end else if (length_fail) begin
            verdict = VERDICT_PAYLOAD;
        end else begin
            verdict = VERDICT_MATCH;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/crf_counters.sv =====
`timescale 1ns / 1ps
`default_nettype none

module crf_counters
    import crf_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  step_t                                step,
    input  logic [LIMIT_W-1:0]                   match_limit,
    output outcome_t                             outcome,
    output logic [CNT_NUM-1:0][COUNT_WIDTH-1:0]  counts
);

    localparam int CmpW = (COUNT_WIDTH > LIMIT_W) ? COUNT_WIDTH : LIMIT_W;

    logic [CNT_NUM-1:0][COUNT_WIDTH-1:0] cnt_reg;
    logic [CNT_NUM-1:0][COUNT_WIDTH-1:0] cnt_next;
    logic [CNT_NUM-1:0]                  bump;
    logic [CmpW-1:0]                     limit_ext;
    logic                                limit_on;
    logic                                limit_now;

    assign limit_ext = CmpW'(match_limit);
    assign limit_on  = (match_limit != '0);
    assign limit_now = limit_on && (CmpW'(cnt_reg[CNT_MATCHED]) >= limit_ext);

    always_comb begin
        bump = '0;
        if (!limit_now) begin
            bump[CNT_SCANNED] = 1'b1;
            case (step.verdict)
                VERDICT_MATCH:   bump[CNT_MATCHED] = 1'b1;
                VERDICT_TIME:    bump[CNT_TIME]    = 1'b1;
                VERDICT_DEVICE:  bump[CNT_DEVICE]  = 1'b1;
                VERDICT_KIND:    bump[CNT_KIND]    = 1'b1;
                VERDICT_PAYLOAD: bump[CNT_PAYLOAD] = 1'b1;
                default:         ;
            endcase
        end
    end

    // saturating increments
    always_comb begin
        for (int i = 0; i < CNT_NUM; i++) begin
            if (step.advance && bump[i] && (cnt_reg[i] != {COUNT_WIDTH{1'b1}})) begin
                cnt_next[i] = cnt_reg[i] + COUNT_WIDTH'(1);
            end else begin
                cnt_next[i] = cnt_reg[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    assign outcome.verdict       = limit_now ? VERDICT_IGNORED : step.verdict;
    assign outcome.limit_reached = limit_on &&
        (CmpW'(cnt_next[CNT_MATCHED]) >= limit_ext);
    assign counts = cnt_next;

endmodule

`default_nettype wire

// ===== rtl/capture_record_filter.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Filters a stream of capture records (time, device, kind, payload length) against the
// enabled checks set over the APB port and returns one result per record: the verdict,
// whether the match limit has been reached, and the six saturating counters as they stand
// after that record. A record goes from the s_ transfer through the input register, then the
// result register, to m_tvalid; one record is taken every cycle while m_tready does not stall
// the result side. The counter bank compares against the match limit and does its saturating
// increment combinationally, so it never holds the flow. Counters clear only at reset. Write
// the registers only while no record is in flight.

module capture_record_filter
    import crf_pkg::*;
#(
    parameter int COUNT_WIDTH  = COUNT_WIDTH_DEF,
    parameter int DEVICE_WIDTH = DEVICE_WIDTH_DEF,
    parameter int LENGTH_WIDTH = LENGTH_WIDTH_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,

    input  logic                  s_tvalid,
    output logic                  s_tready,
    // capture_time, device_id, packet_kind, payload_length
    input  logic [S_TDATA_W-1:0]  s_tdata,

    output logic                  m_tvalid,
    input  logic                  m_tready,
    // verdict, limit_reached, scanned_total, matched_total, time_rejects,
    // device_rejects, kind_rejects, payload_rejects, zero pad
    output logic [M_TDATA_W-1:0]  m_tdata
);

    cfg_t                               cfg_reg;
    reg_idx_t                           reg_idx;
    logic                               cfg_write;

    logic                               in_valid_reg;
    record_t                            in_rec_reg;
    logic                               out_valid_reg;
    outcome_t                           out_outcome_reg;
    logic [CNT_NUM-1:0][TOTAL_W-1:0]    out_totals_reg;
    logic [CNT_NUM-1:0][TOTAL_W-1:0]    totals_next;

    logic                               out_free;
    logic                               advance;
    verdict_t                           check_verdict;
    step_t                              step;
    outcome_t                           outcome;
    logic [CNT_NUM-1:0][COUNT_WIDTH-1:0] counts;

    // configuration port
    assign pready    = 1'b1;
    assign reg_idx   = reg_idx_t'(paddr[REG_LSB +: REG_IDX_W]);
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_write) begin
            case (reg_idx)
                REG_CHECK_ENABLES: cfg_reg.check_enables <= pwdata[ENABLES_W-1:0];
                REG_WINDOW_START:  cfg_reg.window_start  <= pwdata[TIME_W-1:0];
                REG_WINDOW_END:    cfg_reg.window_end    <= pwdata[TIME_W-1:0];
                REG_WANTED_DEVICE: cfg_reg.wanted_device <= pwdata[DEVICE_W-1:0];
                REG_WANTED_KIND:   cfg_reg.wanted_kind   <= pwdata[KIND_W-1:0];
                REG_LEAST_PAYLOAD: cfg_reg.least_payload <= pwdata[LENGTH_W-1:0];
                REG_MOST_PAYLOAD:  cfg_reg.most_payload  <= pwdata[LENGTH_W-1:0];
                REG_MATCH_LIMIT:   cfg_reg.match_limit   <= pwdata[LIMIT_W-1:0];
                default:           ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_CHECK_ENABLES: prdata = APB_DATA_W'(cfg_reg.check_enables);
            REG_WINDOW_START:  prdata = APB_DATA_W'(cfg_reg.window_start);
            REG_WINDOW_END:    prdata = APB_DATA_W'(cfg_reg.window_end);
            REG_WANTED_DEVICE: prdata = APB_DATA_W'(cfg_reg.wanted_device);
            REG_WANTED_KIND:   prdata = APB_DATA_W'(cfg_reg.wanted_kind);
            REG_LEAST_PAYLOAD: prdata = APB_DATA_W'(cfg_reg.least_payload);
            REG_MOST_PAYLOAD:  prdata = APB_DATA_W'(cfg_reg.most_payload);
            REG_MATCH_LIMIT:   prdata = APB_DATA_W'(cfg_reg.match_limit);
            default:           prdata = '0;
        endcase
    end

    // two-stage flow
    assign out_free = !out_valid_reg || m_tready;
    assign advance  = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_rec_reg <= record_t'(s_tdata);
        end
    end

    crf_checks #(
        .DEVICE_WIDTH (DEVICE_WIDTH),
        .LENGTH_WIDTH (LENGTH_WIDTH)
    ) u_checks (
        .rec     (in_rec_reg),
        .cfg     (cfg_reg),
        .verdict (check_verdict)
    );

    assign step.advance = advance;
    assign step.verdict = check_verdict;

    crf_counters #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_counters (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .step        (step),
        .match_limit (cfg_reg.match_limit),
        .outcome     (outcome),
        .counts      (counts)
    );

    always_comb begin
        for (int i = 0; i < CNT_NUM; i++) begin
            totals_next[i] = TOTAL_W'(counts[i]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_outcome_reg <= outcome;
            out_totals_reg  <= totals_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {
        {M_PAD_W{1'b0}},
        out_totals_reg,
        out_outcome_reg.limit_reached,
        out_outcome_reg.verdict
    };

    // an ignored record can only leave while the limit still holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && (out_outcome_reg.verdict == VERDICT_IGNORED))
            |-> out_outcome_reg.limit_reached)
        else $error("ignored record without limit reached");

    // a record moving forward always shows up on the result side
    assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> out_valid_reg)
        else $error("record lost between stages");

    // an empty input stage never stalls the input side
    assert property (@(posedge aclk) disable iff (!aresetn)
        !in_valid_reg |-> s_tready)
        else $error("input stalled while empty");

endmodule

`default_nettype wire

// ===== sim/crf_checker.sv =====
`timescale 1ns / 1ps

module crf_checker
    import crf_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic                  pready,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [M_TDATA_W-1:0]  m_tdata,
    output int                    error_count,
    output int                    results_due
);

    // m_tdata layout, lowest bits last
    typedef struct packed {
        logic [M_PAD_W-1:0] pad;
        logic [TOTAL_W-1:0] payload_rejects;
        logic [TOTAL_W-1:0] kind_rejects;
        logic [TOTAL_W-1:0] device_rejects;
        logic [TOTAL_W-1:0] time_rejects;
        logic [TOTAL_W-1:0] matched_total;
        logic [TOTAL_W-1:0] scanned_total;
        logic               limit_reached;
        verdict_t           verdict;
    } filter_result_t;

    cfg_t                         filter_cfg;
    logic [COUNT_WIDTH_DEF-1:0]   tally [CNT_NUM];
    filter_result_t               expected_q [$];

    initial begin
        error_count = 0;
        results_due = 0;
    end

    function automatic void bump_tally(input int slot);
        if (tally[slot] != '1) begin
            tally[slot] = tally[slot] + 1'b1;
        end
    endfunction

    function automatic logic limit_hit();
        return filter_cfg.match_limit != '0 && tally[CNT_MATCHED] >= filter_cfg.match_limit;
    endfunction

    function automatic filter_result_t judge_record(input record_t rec);
        filter_result_t res;
        verdict_t       v;
        logic [ENABLES_W-1:0] en;
        en = filter_cfg.check_enables;
        if (limit_hit()) begin
            v = VERDICT_IGNORED;
        end else begin
            bump_tally(CNT_SCANNED);
            if ((en[EN_START] && rec.capture_time < filter_cfg.window_start) ||
                (en[EN_END] && rec.capture_time > filter_cfg.window_end)) begin
                v = VERDICT_TIME;
                bump_tally(CNT_TIME);
            end else if (en[EN_DEVICE] && rec.device_id[DEVICE_WIDTH_DEF-1:0] !=
                         filter_cfg.wanted_device[DEVICE_WIDTH_DEF-1:0]) begin
                v = VERDICT_DEVICE;
                bump_tally(CNT_DEVICE);
            end else if (en[EN_KIND] && rec.packet_kind != filter_cfg.wanted_kind) begin
                v = VERDICT_KIND;
                bump_tally(CNT_KIND);
            end else if ((en[EN_MINLEN] && rec.payload_length[LENGTH_WIDTH_DEF-1:0] <
                          filter_cfg.least_payload[LENGTH_WIDTH_DEF-1:0]) ||
                         (en[EN_MAXLEN] && rec.payload_length[LENGTH_WIDTH_DEF-1:0] >
                          filter_cfg.most_payload[LENGTH_WIDTH_DEF-1:0])) begin
                v = VERDICT_PAYLOAD;
                bump_tally(CNT_PAYLOAD);
            end else begin
                v = VERDICT_MATCH;
                bump_tally(CNT_MATCHED);
            end
        end
        res = '0;
        res.verdict         = v;
        res.limit_reached   = limit_hit();
        res.scanned_total   = TOTAL_W'(tally[CNT_SCANNED]);
        res.matched_total   = TOTAL_W'(tally[CNT_MATCHED]);
        res.time_rejects    = TOTAL_W'(tally[CNT_TIME]);
        res.device_rejects  = TOTAL_W'(tally[CNT_DEVICE]);
        res.kind_rejects    = TOTAL_W'(tally[CNT_KIND]);
        res.payload_rejects = TOTAL_W'(tally[CNT_PAYLOAD]);
        return res;
    endfunction

    function automatic void take_write(input reg_idx_t idx, input logic [APB_DATA_W-1:0] value);
        case (idx)
            REG_CHECK_ENABLES: filter_cfg.check_enables = value[ENABLES_W-1:0];
            REG_WINDOW_START:  filter_cfg.window_start  = value[TIME_W-1:0];
            REG_WINDOW_END:    filter_cfg.window_end    = value[TIME_W-1:0];
            REG_WANTED_DEVICE: filter_cfg.wanted_device = value[DEVICE_W-1:0];
            REG_WANTED_KIND:   filter_cfg.wanted_kind   = value[KIND_W-1:0];
            REG_LEAST_PAYLOAD: filter_cfg.least_payload = value[LENGTH_W-1:0];
            REG_MOST_PAYLOAD:  filter_cfg.most_payload  = value[LENGTH_W-1:0];
            REG_MATCH_LIMIT:   filter_cfg.match_limit   = value[LIMIT_W-1:0];
            default: ;
        endcase
    endfunction

    function automatic void check_field(input string name, input logic [TOTAL_W-1:0] want,
                                        input logic [TOTAL_W-1:0] got);
        if (got !== want) begin
            error_count++;
            if (error_count <= 10) begin
                $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
            end
        end
    endfunction

    function automatic void compare_result(input filter_result_t got);
        filter_result_t want;
        if (expected_q.size() == 0) begin
            error_count++;
            if (error_count <= 10) begin
                $display("%0t: result transfer with no record outstanding, got %0h",
                         $time, got);
            end
        end else begin
            want = expected_q.pop_front();
            check_field("verdict", TOTAL_W'(want.verdict), TOTAL_W'(got.verdict));
            check_field("limit_reached", TOTAL_W'(want.limit_reached),
                        TOTAL_W'(got.limit_reached));
            check_field("scanned_total", want.scanned_total, got.scanned_total);
            check_field("matched_total", want.matched_total, got.matched_total);
            check_field("time_rejects", want.time_rejects, got.time_rejects);
            check_field("device_rejects", want.device_rejects, got.device_rejects);
            check_field("kind_rejects", want.kind_rejects, got.kind_rejects);
            check_field("payload_rejects", want.payload_rejects, got.payload_rejects);
        end
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            filter_cfg = '0;
            foreach (tally[i]) tally[i] = '0;
            expected_q.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                take_write(reg_idx_t'(paddr[REG_LSB +: REG_IDX_W]), pwdata);
            end
            // results first, so a record accepted now can never satisfy an early result
            if (m_tvalid && m_tready) begin
                compare_result(filter_result_t'(m_tdata));
            end
            if (s_tvalid && s_tready) begin
                expected_q.insert(expected_q.size(), judge_record(record_t'(s_tdata)));
            end
        end
        results_due = expected_q.size();
    end

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
    import crf_pkg::*;

    logic                  aclk     = 1'b0;
    logic                  aresetn  = 1'b0;
    logic                  psel     = 1'b0;
    logic                  penable  = 1'b0;
    logic                  pwrite   = 1'b0;
    logic [APB_ADDR_W-1:0] paddr    = '0;
    logic [APB_DATA_W-1:0] pwdata   = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    // capture_time, device_id, packet_kind, payload_length
    logic [S_TDATA_W-1:0]  s_tdata  = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    // verdict, limit_reached, scanned_total, matched_total, time_rejects,
    // device_rejects, kind_rejects, payload_rejects, zero pad
    logic [M_TDATA_W-1:0]  m_tdata;

    int   error_count;
    int   results_due;
    int   send_gap_pct   = 37;
    int   ready_stall_pct = 54;
    cfg_t filter_setup;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    capture_record_filter DUT (
        .aclk, .aresetn,
        .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
        .s_tvalid, .s_tready, .s_tdata,
        .m_tvalid, .m_tready, .m_tdata
    );

    crf_checker u_checker (
        .aclk, .aresetn,
        .psel, .penable, .pwrite, .pready, .paddr, .pwdata,
        .s_tvalid, .s_tready, .s_tdata,
        .m_tvalid, .m_tready, .m_tdata,
        .error_count, .results_due
    );

    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= ready_stall_pct);
    end

    initial begin
        #5_000_000;
        $display("capture_record_filter regression: fail");
        $finish;
    end

    function automatic logic [63:0] rand_word();
        return {$urandom, $urandom};
    endfunction

    function automatic record_t make_record(input logic [63:0] t, input logic [15:0] dev,
                                            input logic [7:0] kind, input logic [15:0] len);
        record_t rec;
        rec.capture_time   = t;
        rec.device_id      = dev;
        rec.packet_kind    = kind;
        rec.payload_length = len;
        return rec;
    endfunction

    // records mostly land near the active bounds and wanted values
    function automatic record_t random_record();
        record_t     rec;
        logic [63:0] span;
        span = filter_setup.window_end - filter_setup.window_start;
        case ($urandom_range(9))
            0: rec.capture_time = '0;
            1: rec.capture_time = '1;
            2: rec.capture_time = rand_word();
            3: rec.capture_time = filter_setup.window_start - 64'($urandom_range(1));
            4: rec.capture_time = filter_setup.window_end + 64'($urandom_range(1));
            default: begin
                if (filter_setup.window_start > filter_setup.window_end || span == '1) begin
                    rec.capture_time = rand_word();
                end else begin
                    rec.capture_time = filter_setup.window_start + rand_word() % (span + 1);
                end
            end
        endcase
        rec.device_id = ($urandom_range(3) == 0) ? 16'($urandom) : filter_setup.wanted_device;
        rec.packet_kind = ($urandom_range(3) == 0) ? 8'($urandom) : filter_setup.wanted_kind;
        case ($urandom_range(7))
            0: rec.payload_length = '0;
            1: rec.payload_length = '1;
            2: rec.payload_length = filter_setup.least_payload - 1'b1;
            3: rec.payload_length = filter_setup.most_payload + 1'b1;
            4: rec.payload_length = filter_setup.least_payload;
            5: rec.payload_length = filter_setup.most_payload;
            default: begin
                if (filter_setup.least_payload <= filter_setup.most_payload) begin
                    rec.payload_length = filter_setup.least_payload + 16'($urandom_range(
                        filter_setup.most_payload - filter_setup.least_payload));
                end else begin
                    rec.payload_length = 16'($urandom);
                end
            end
        endcase
        return rec;
    endfunction

    function automatic cfg_t random_filter();
        cfg_t c;
        c.check_enables = 6'($urandom);
        case ($urandom_range(4))
            0: begin
                c.window_start = '0;
                c.window_end   = '1;
            end
            1: begin
                c.window_start = '1;
                c.window_end   = '0;
            end
            2: begin
                c.window_start = rand_word();
                c.window_end   = c.window_start;
            end
            default: begin
                c.window_start = rand_word() >> $urandom_range(63);
                c.window_end   = c.window_start + (rand_word() >> $urandom_range(63));
            end
        endcase
        c.wanted_device = 16'($urandom);
        c.wanted_kind   = 8'($urandom);
        case ($urandom_range(3))
            0: begin
                c.least_payload = '0;
                c.most_payload  = '1;
            end
            1: begin
                c.least_payload = '1;
                c.most_payload  = '0;
            end
            default: begin
                c.least_payload = 16'($urandom_range(4000));
                c.most_payload  = c.least_payload + 16'($urandom_range(4000));
            end
        endcase
        case ($urandom_range(7))
            0: c.match_limit = '1;
            1, 2: c.match_limit = 32'($urandom_range(1500, 1));
            default: c.match_limit = '0;
        endcase
        return c;
    endfunction

    task automatic write_reg(input reg_idx_t idx, input logic [APB_DATA_W-1:0] value);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = APB_ADDR_W'(idx) << REG_LSB;
        pwdata  = value;
        @(negedge aclk);
        penable = 1'b1;
        do @(posedge aclk); while (!pready);
        @(negedge aclk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic apply_filter(input cfg_t c);
        filter_setup = c;
        write_reg(REG_CHECK_ENABLES, APB_DATA_W'(c.check_enables));
        write_reg(REG_WINDOW_START, APB_DATA_W'(c.window_start));
        write_reg(REG_WINDOW_END, APB_DATA_W'(c.window_end));
        write_reg(REG_WANTED_DEVICE, APB_DATA_W'(c.wanted_device));
        write_reg(REG_WANTED_KIND, APB_DATA_W'(c.wanted_kind));
        write_reg(REG_LEAST_PAYLOAD, APB_DATA_W'(c.least_payload));
        write_reg(REG_MOST_PAYLOAD, APB_DATA_W'(c.most_payload));
        write_reg(REG_MATCH_LIMIT, APB_DATA_W'(c.match_limit));
    endtask

    task automatic send_record(input record_t rec);
        while ($urandom_range(99) < send_gap_pct) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = rec;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    task automatic drain();
        s_tvalid = 1'b0;
        while (results_due != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    initial begin
        cfg_t c;
        repeat (11) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);
        filter_setup = '0;

        // every check off after reset, field extremes pass
        send_record(make_record('0, '0, '0, '0));
        send_record(make_record('1, '1, '1, '1));

        drain();
        c = '0;
        c.check_enables = '1;
        c.window_start  = 64'd100;
        c.window_end    = 64'd200;
        c.wanted_device = 16'h1234;
        c.wanted_kind   = 8'h5a;
        c.least_payload = 16'd10;
        c.most_payload  = 16'd20;
        apply_filter(c);
        send_record(make_record(64'd99, 16'h1234, 8'h5a, 16'd15));
        send_record(make_record(64'd201, 16'h1234, 8'h5a, 16'd15));
        send_record(make_record(64'd100, 16'h1235, 8'h5a, 16'd15));
        send_record(make_record(64'd200, 16'h1234, 8'h5b, 16'd15));
        send_record(make_record(64'd150, 16'h1234, 8'h5a, 16'd9));
        send_record(make_record(64'd150, 16'h1234, 8'h5a, 16'd21));
        send_record(make_record(64'd100, 16'h1234, 8'h5a, 16'd10));
        send_record(make_record(64'd200, 16'h1234, 8'h5a, 16'd20));

        // inverted window rejects everything by time
        drain();
        c.check_enables = 6'h03;
        c.window_start  = '1;
        c.window_end    = '0;
        apply_filter(c);
        send_record(make_record('0, '0, '0, '0));
        send_record(make_record('1, '1, '1, '1));

        // limit already below the match count, then raised, then cleared
        drain();
        c.check_enables = '0;
        c.match_limit   = 32'd1;
        apply_filter(c);
        send_record(make_record(rand_word(), 16'($urandom), 8'($urandom), 16'($urandom)));
        drain();
        write_reg(REG_MATCH_LIMIT, 64'd6);
        filter_setup.match_limit = 32'd6;
        repeat (3) send_record(make_record(rand_word(), 16'($urandom), 8'($urandom),
                                           16'($urandom)));
        drain();
        write_reg(REG_MATCH_LIMIT, 64'd0);
        filter_setup.match_limit = '0;
        send_record(make_record(rand_word(), 16'($urandom), 8'($urandom), 16'($urandom)));

        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    send_gap_pct    = 37;
                    ready_stall_pct = 54;
                end
                1: begin
                    send_gap_pct    = 54;
                    ready_stall_pct = 37;
                end
                default: begin
                    send_gap_pct    = 0;
                    ready_stall_pct = 0;
                end
            endcase
            for (int seg = 0; seg < 3; seg++) begin
                drain();
                apply_filter(random_filter());
                repeat (110) send_record(random_record());
            end
        end

        drain();
        repeat (8) @(negedge aclk);
        if (error_count == 0 && results_due == 0) begin
            $display("capture_record_filter regression: pass");
        end else begin
            $display("capture_record_filter regression: fail");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/crf_pkg.sv
rtl/crf_checks.sv
rtl/crf_counters.sv
rtl/capture_record_filter.sv
sim/crf_checker.sv
sim/tb_top.sv
